### rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/lfr_pkg.sv
package lfr_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } lfr_op_t;

  // Register indexes
  localparam int unsigned REG_ADDR_W = 2;
  typedef enum logic [REG_ADDR_W-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_WAIT  = 2'd2
  } lfr_reg_t;

  // Register reset values
  localparam logic [7:0]  START_RESET = 8'd187;
  localparam logic [7:0]  END_RESET   = 8'd126;
  localparam logic [15:0] WAIT_RESET  = 16'd1000;

  // Frame layout
  localparam int unsigned HDR_BYTES      = 5;
  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned LEN_HI_POS     = 3;
  localparam int unsigned LEN_LO_POS     = 4;
  localparam int unsigned LEN_SUM_W      = 17;
  localparam int unsigned OUT_LEN_W      = 9;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    lfr_op_t    op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } lfr_cmd_t;

  typedef struct packed {
    logic                 frame_ready;
    logic [OUT_LEN_W-1:0] frame_length;
    logic                 read_hit;
    logic                 timed_out;
    logic                 byte_taken;
  } lfr_res_t;

endpackage

### rtl/lfr_if.sv
// Input item channel
interface lfr_in_if;
  import lfr_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [7:0] read_index;
  modport source (output valid, kind, rx_byte, read_index, input ready);
  modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

// Result item channel
interface lfr_out_if;
  import lfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 frame_ready;
  logic [OUT_LEN_W-1:0] frame_length;
  logic [7:0]           read_data;
  logic                 timed_out;
  logic                 byte_taken;
  modport source (output valid, frame_ready, frame_length, read_data, timed_out,
                  byte_taken, input ready);
  modport sink   (input valid, frame_ready, frame_length, read_data, timed_out,
                  byte_taken, output ready);
endinterface

// Register write channel
interface lfr_cfg_if;
  import lfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_ADDR_W-1:0] addr;
  logic [15:0]           data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/lfr_front.sv
`include "assert_macros.svh"

module lfr_front (
  input  logic              clk,
  input  logic              rst_n,
  lfr_in_if.sink            in_chan,
  output logic              q_valid,
  input  logic              q_ready,
  output lfr_pkg::lfr_cmd_t q_cmd
);
  import lfr_pkg::*;

  lfr_cmd_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push, pop;
  lfr_cmd_t             cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.rx_byte    = in_chan.rx_byte;
    cmd_in.read_index = in_chan.read_index;
    cmd_in.op         = lfr_op_t'(in_chan.kind);
  end

  assign in_chan.ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != '0);
  assign pop           = q_valid && q_ready;
  assign q_cmd         = entry_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  `CHK_IMPL(a_count_bound, 1'b1, count_r <= Q_CNT_W'(Q_DEPTH))
  `CHK_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + Q_CNT_W'(1))
  `CHK_IMPL(a_ptr_count, 1'b1, (wr_ptr_r == rd_ptr_r) == (count_r != Q_CNT_W'(1)))

endmodule

### rtl/lfr_back.sv
`include "assert_macros.svh"

module lfr_back #(
  parameter int FRAME_CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  lfr_pkg::lfr_cmd_t q_cmd,
  lfr_cfg_if.sink           cfg_chan,
  lfr_out_if.source         out_chan
);
  import lfr_pkg::*;

  localparam int FW = $clog2(FRAME_CAPACITY + 1);
  localparam int AW = $clog2(FRAME_CAPACITY);
  localparam logic [FW-1:0]        CAP_F = FW'(FRAME_CAPACITY);
  localparam logic [LEN_SUM_W-1:0] CAP_E = LEN_SUM_W'(FRAME_CAPACITY);

  // Frame store
  logic [7:0] mem [FRAME_CAPACITY];
  logic [7:0] mem_rd_r;

  // Registers and frame state
  logic [7:0]  start_r, end_r;
  logic [15:0] wait_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic        closed_r, closed_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;

  // Output register
  logic     out_valid_r;
  lfr_res_t out_r;

  logic                 exec;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        rd_addr;
  logic [FW-1:0]        fill_inc;
  logic [LEN_SUM_W-1:0] expected;
  logic                 taken;
  logic                 rd_hit;
  logic [7:0]           b;

  assign exec    = q_valid && (!out_valid_r || out_chan.ready);
  assign q_ready = !out_valid_r || out_chan.ready;
  assign b       = q_cmd.rx_byte;
  assign rd_addr = AW'(q_cmd.read_index);
  assign fill_inc = fill_r + FW'(1);

  // Register writes
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
      end_r   <= END_RESET;
      wait_r  <= WAIT_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        REG_START: start_r <= cfg_chan.data[7:0];
        REG_END:   end_r   <= cfg_chan.data[7:0];
        REG_WAIT:  wait_r  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Execute one item
  always_comb begin
    fill_nxt   = fill_r;
    closed_nxt = closed_r;
    idle_nxt   = idle_r;
    len_hi_nxt = len_hi_r;
    len_lo_nxt = len_lo_r;
    mem_we     = 1'b0;
    mem_waddr  = fill_r[AW-1:0];
    taken      = 1'b0;
    rd_hit     = 1'b0;
    expected   = '0;
    if (exec) begin
      unique case (q_cmd.op)
        OP_BYTE: begin
          if (!closed_r && !(fill_r == '0 && b != start_r) && fill_r < CAP_F) begin
            taken    = 1'b1;
            mem_we   = 1'b1;
            fill_nxt = fill_inc;
            idle_nxt = wait_r;
            if (fill_r == FW'(LEN_HI_POS)) begin
              len_hi_nxt = b;
            end
            if (fill_r == FW'(LEN_LO_POS)) begin
              len_lo_nxt = b;
            end
            expected = {1'b0, len_hi_nxt, len_lo_nxt} + LEN_SUM_W'(FRAME_OVERHEAD);
            if (fill_inc >= FW'(HDR_BYTES)) begin
              if (expected > CAP_E) begin
                fill_nxt = '0;
              end else if (LEN_SUM_W'(fill_inc) >= expected) begin
                if (LEN_SUM_W'(fill_inc) == expected && b == end_r) begin
                  closed_nxt = 1'b1;
                end else if (b == start_r) begin
                  // drop and reopen with this byte at the head
                  fill_nxt  = FW'(1);
                  mem_waddr = '0;
                end else begin
                  fill_nxt = '0;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (idle_r != '0) begin
            idle_nxt = idle_r - 16'd1;
          end
        end
        OP_RELEASE: begin
          fill_nxt   = '0;
          closed_nxt = 1'b0;
        end
        OP_READ: begin
          rd_hit = LEN_SUM_W'(q_cmd.read_index) < LEN_SUM_W'(fill_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      closed_r <= 1'b0;
      idle_r   <= WAIT_RESET;
      len_hi_r <= '0;
      len_lo_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      closed_r <= closed_nxt;
      idle_r   <= idle_nxt;
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= b;
    end
    if (exec && q_cmd.op == OP_READ) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r.frame_ready  <= closed_nxt;
      out_r.frame_length <= OUT_LEN_W'(fill_nxt);
      out_r.read_hit     <= rd_hit;
      out_r.timed_out    <= (idle_nxt == '0);
      out_r.byte_taken   <= taken;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_ready  = out_r.frame_ready;
  assign out_chan.frame_length = out_r.frame_length;
  assign out_chan.read_data    = out_r.read_hit ? mem_rd_r : 8'd0;
  assign out_chan.timed_out    = out_r.timed_out;
  assign out_chan.byte_taken   = out_r.byte_taken;

  `CHK_IMPL(a_fill_cap, 1'b1, fill_r <= CAP_F)
  `CHK_IMPL(a_closed_min, closed_r, LEN_SUM_W'(fill_r) >= LEN_SUM_W'(FRAME_OVERHEAD))
  `CHK_NEXT(a_closed_hold, closed_r && !(exec && q_cmd.op == OP_RELEASE), closed_r)
  `CHK_NEXT(a_tick_no_take, exec && q_cmd.op == OP_TICK, out_r.byte_taken == 1'b0)

endmodule

### rtl/length_delimited_frame_receiver_top.sv
// Length-delimited frame receiver.
// in_chan carries one item per handshake: a received byte, an idle tick,
// a frame release or a read of a stored byte. out_chan returns exactly one
// result item per input item, in order: frame_ready, frame_length,
// read_data, timed_out and byte_taken after that item.
// cfg_chan writes start_byte, end_byte and wait_ticks by index; it is
// always ready. It is to be used only while no item is in flight; the
// block itself does not enforce this.
// An accepted item is registered in the front queue, then passes from the
// queue through the execute stage into the result register.
// Throughput: one item per cycle while out_chan takes results, set by the
// single write or read of the frame store per item in the execute stage.
// A two-entry queue parts the front from the execute stage, and the result
// register lets the next item execute in the cycle its result is taken. A
// stalled receiver fills the result register, then the queue, then drops
// in_chan.ready.
// Reset (rst_n low, synchronous) restores register defaults, empties the
// frame and reloads the idle counter; store contents are left as they are.

module length_delimited_frame_receiver_top #(
  parameter int FRAME_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  lfr_in_if.sink     in_chan,
  lfr_out_if.source  out_chan,
  lfr_cfg_if.sink    cfg_chan
);
  import lfr_pkg::*;

  logic     q_valid;
  logic     q_ready;
  lfr_cmd_t q_cmd;

  lfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  lfr_back #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

endmodule
